// File: hdl/bgs_pkg.sv
// Shared widths, register codes and pixel count helper for the gutter snap block.
`default_nettype none

package bgs_pkg;

	// Field widths fixed by the register map and the stream payloads
	localparam int unsigned ROW_WIDTH_W = 13;
	localparam int unsigned PERCENT_W   = 7;
	localparam int unsigned FLOOR_W     = 13;
	localparam int unsigned ROWNUM_W    = 16;
	localparam int unsigned MIN_RUN_W   = 8;
	localparam int unsigned PAD_W       = 8;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned PIXEL_W     = 8;
	localparam int unsigned INK_OUT_W   = 13;
	localparam int unsigned LANDING_W   = 16;
	// bytes per row, up to ceil(8191 / 8)
	localparam int unsigned BYTES_W     = ROW_WIDTH_W - 2;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_WIDTH       = 3'd0,
		REG_GAP_INK_PERCENT = 3'd1,
		REG_GAP_INK_FLOOR   = 3'd2,
		REG_TARGET_ROW      = 3'd3,
		REG_TOLERANCE       = 3'd4,
		REG_FIRST_ROW       = 3'd5,
		REG_MIN_GUTTER_ROWS = 3'd6,
		REG_GUTTER_PAD      = 3'd7
	} cfg_reg_t;

	// Set bits per nibble
	localparam logic [2:0] NIBBLE_ONES [16] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
		3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
	};

	// Set bits in one pixel byte
	function automatic logic [3:0] ones8(input logic [PIXEL_W-1:0] b);
		return {1'b0, NIBBLE_ONES[b[3:0]]} + {1'b0, NIBBLE_ONES[b[7:4]]};
	endfunction

endpackage

`default_nettype wire

// File: hdl/bgs_pix_if.sv
// Pixel byte stream channel: valid/ready with one packed byte and the window end flag.
`default_nettype none

interface bgs_pix_if;
	logic                         valid;
	logic                         ready;
	logic [bgs_pkg::PIXEL_W-1:0]  pixel_byte;
	logic                         window_end;

	modport source (output valid, output pixel_byte, output window_end, input ready);
	modport sink   (input valid, input pixel_byte, input window_end, output ready);
endinterface

`default_nettype wire

// File: hdl/bgs_row_if.sv
// Row result channel: valid/ready with the per-row ink report and the window landing.
`default_nettype none

interface bgs_row_if;
	logic                           valid;
	logic                           ready;
	logic [bgs_pkg::INK_OUT_W-1:0]  row_ink;
	logic                           row_is_gap;
	logic                           window_done;
	logic [bgs_pkg::LANDING_W-1:0]  landing_row;
	logic                           landing_found;

	modport source (output valid, output row_ink, output row_is_gap, output window_done,
		output landing_row, output landing_found, input ready);
	modport sink   (input valid, input row_ink, input row_is_gap, input window_done,
		input landing_row, input landing_found, output ready);
endinterface

`default_nettype wire

// File: hdl/bitmap_gutter_snap_top.sv
// Gutter snap top level: row ink counter, gap run tracker and landing selector.
// Pixel bytes are taken one per clock unless a stalled result sink holds them;
// no row or window boundary stalls the input. A request passes three registers:
// the input register (ink count and gap test), the row register (gap run and
// landing pick) and the result register, which holds the row's result.
// Only a row's last byte (or a byte with window_end) makes a result; other
// bytes only update the running ink sum. A stalled result sink backs up into
// the row and input registers, so up to three requests are held before ready
// drops. Configuration writes take effect on the next request and must be made
// while no result is outstanding. There is no clearing pass after reset.
`default_nettype none

module bitmap_gutter_snap_top #(
	parameter int unsigned MAX_ROW_PIXELS = 4096,
	parameter int unsigned ROW_INDEX_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [bgs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bgs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	bgs_pix_if.sink                            pixels,
	bgs_row_if.source                          rows
);

	localparam int unsigned WIDTH_LIMIT = (1 << bgs_pkg::ROW_WIDTH_W) - 1;
	localparam int unsigned WIDTH_CAP   =
		(MAX_ROW_PIXELS < WIDTH_LIMIT) ? MAX_ROW_PIXELS : WIDTH_LIMIT;
	localparam int unsigned BYTES_MAX   = (WIDTH_CAP + 7) / 8;
	localparam int unsigned BYTE_IDX_W  = (BYTES_MAX > 1) ? $clog2(BYTES_MAX) : 1;
	localparam int unsigned INK_W       = $clog2(8 * BYTES_MAX + 1);
	localparam int unsigned PROD_W      = bgs_pkg::ROW_WIDTH_W + bgs_pkg::PERCENT_W;
	localparam int unsigned INK100_W    = INK_W + 7;
	localparam int unsigned GAP_CMP_A   = (PROD_W > INK100_W) ? PROD_W : INK100_W;
	localparam int unsigned GAP_CMP_W   =
		(GAP_CMP_A > bgs_pkg::FLOOR_W) ? GAP_CMP_A : bgs_pkg::FLOOR_W;
	localparam int unsigned DIST_W      =
		(ROW_INDEX_BITS > bgs_pkg::LANDING_W) ? ROW_INDEX_BITS : bgs_pkg::LANDING_W;

	// Configuration registers
	logic [bgs_pkg::ROW_WIDTH_W-1:0] row_width_q;
	logic [bgs_pkg::PERCENT_W-1:0]   gap_percent_q;
	logic [bgs_pkg::FLOOR_W-1:0]     gap_floor_q;
	logic [bgs_pkg::LANDING_W-1:0]   target_row_q;
	logic [bgs_pkg::LANDING_W-1:0]   tolerance_q;
	logic [bgs_pkg::ROWNUM_W-1:0]    first_row_q;
	logic [bgs_pkg::MIN_RUN_W-1:0]   min_gutter_q;
	logic [bgs_pkg::PAD_W-1:0]       gutter_pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= bgs_pkg::ROW_WIDTH_W'(480);
			gap_percent_q <= bgs_pkg::PERCENT_W'(2);
			gap_floor_q   <= bgs_pkg::FLOOR_W'(2);
			target_row_q  <= '0;
			tolerance_q   <= '0;
			first_row_q   <= '0;
			min_gutter_q  <= bgs_pkg::MIN_RUN_W'(4);
			gutter_pad_q  <= bgs_pkg::PAD_W'(4);
		end else if (cfg_wr_en) begin
			case (bgs_pkg::cfg_reg_t'(cfg_index))
				bgs_pkg::REG_ROW_WIDTH:       row_width_q   <= cfg_wdata[bgs_pkg::ROW_WIDTH_W-1:0];
				bgs_pkg::REG_GAP_INK_PERCENT: gap_percent_q <= cfg_wdata[bgs_pkg::PERCENT_W-1:0];
				bgs_pkg::REG_GAP_INK_FLOOR:   gap_floor_q   <= cfg_wdata[bgs_pkg::FLOOR_W-1:0];
				bgs_pkg::REG_TARGET_ROW:      target_row_q  <= cfg_wdata;
				bgs_pkg::REG_TOLERANCE:       tolerance_q   <= cfg_wdata;
				bgs_pkg::REG_FIRST_ROW:       first_row_q   <= cfg_wdata;
				bgs_pkg::REG_MIN_GUTTER_ROWS: min_gutter_q  <= cfg_wdata[bgs_pkg::MIN_RUN_W-1:0];
				bgs_pkg::REG_GUTTER_PAD:      gutter_pad_q  <= cfg_wdata[bgs_pkg::PAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline and window state
	logic                         valid_s1;
	logic [bgs_pkg::PIXEL_W-1:0]  pixel_s1;
	logic                         wend_s1;
	logic [BYTE_IDX_W-1:0]        byte_in_row_q;
	logic [INK_W-1:0]             ink_sum_q;
	logic [ROW_INDEX_BITS-1:0]    row_number_q;

	logic                         valid_s2;
	logic [INK_W-1:0]             ink_s2;
	logic                         gap_s2;
	logic                         wend_s2;
	logic [ROW_INDEX_BITS-1:0]    row_s2;
	logic [bgs_pkg::MIN_RUN_W-1:0] run_q;
	logic [bgs_pkg::LANDING_W-1:0] best_land_q;
	logic [bgs_pkg::LANDING_W-1:0] best_dist_q;
	logic                         best_valid_q;

	logic                           out_valid_q;
	logic [bgs_pkg::INK_OUT_W-1:0]  out_ink_q;
	logic                           out_gap_q;
	logic                           out_done_q;
	logic [bgs_pkg::LANDING_W-1:0]  out_land_q;
	logic                           out_found_q;

	// Stage 1: byte position, masking, ink sum and gap test
	logic [bgs_pkg::ROW_WIDTH_W-1:0] width_eff;
	logic                            width_zero;
	logic [bgs_pkg::ROW_WIDTH_W:0]   width_plus7;
	logic [bgs_pkg::BYTES_W-1:0]     bytes_per_row;
	logic                            last_byte;
	logic [2:0]                      tail_bits;
	logic [bgs_pkg::PIXEL_W-1:0]     pixel_mask;
	logic [bgs_pkg::PIXEL_W-1:0]     pixel_kept;
	logic [INK_W-1:0]                ink_new;
	logic [PROD_W-1:0]               budget_x100;
	logic [GAP_CMP_W-1:0]            ink_x100;
	logic                            gap_s1;
	logic                            row_end;

	always_comb begin
		width_eff = (row_width_q > bgs_pkg::ROW_WIDTH_W'(WIDTH_CAP))
			? bgs_pkg::ROW_WIDTH_W'(WIDTH_CAP) : row_width_q;
		width_zero    = (width_eff == '0);
		width_plus7   = {1'b0, width_eff} + (bgs_pkg::ROW_WIDTH_W + 1)'(7);
		bytes_per_row = width_zero ? bgs_pkg::BYTES_W'(1)
			: width_plus7[bgs_pkg::ROW_WIDTH_W:3];
		last_byte = ((bgs_pkg::BYTES_W + 1)'(byte_in_row_q) + (bgs_pkg::BYTES_W + 1)'(1))
			>= {1'b0, bytes_per_row};
		tail_bits  = width_eff[2:0];
		// partial last byte keeps only its leftmost pixels
		pixel_mask = (last_byte && tail_bits != 3'd0) ? ~(8'hFF >> tail_bits) : 8'hFF;
		pixel_kept = width_zero ? '0 : (pixel_s1 & pixel_mask);
		ink_new    = ink_sum_q + INK_W'(bgs_pkg::ones8(pixel_kept));
		row_end    = last_byte || wend_s1;
		// ink <= floor(width*percent/100)  <=>  100*ink <= width*percent
		budget_x100 = PROD_W'(width_eff) * PROD_W'(gap_percent_q);
		ink_x100    = GAP_CMP_W'(ink_new) * GAP_CMP_W'(100);
		gap_s1 = width_zero
			|| (GAP_CMP_W'(ink_new) <= GAP_CMP_W'(gap_floor_q))
			|| (ink_x100 <= GAP_CMP_W'(budget_x100));
	end

	// Handshake between the three registers
	logic out_load_ok;
	logic s2_free;
	logic s2_move;
	logic s1_move;

	always_comb begin
		out_load_ok  = !out_valid_q || rows.ready;
		s2_free      = !valid_s2 || out_load_ok;
		s2_move      = valid_s2 && out_load_ok;
		s1_move      = valid_s1 && (!row_end || s2_free);
		pixels.ready = !valid_s1 || s1_move;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready && pixels.valid) begin
			pixel_s1 <= pixels.pixel_byte;
			wend_s1  <= pixels.window_end;
		end
	end

	// Row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			ink_sum_q     <= '0;
			row_number_q  <= '0;
		end else if (s1_move) begin
			if (row_end) begin
				byte_in_row_q <= '0;
				ink_sum_q     <= '0;
				row_number_q  <= wend_s1 ? '0 : row_number_q + ROW_INDEX_BITS'(1);
			end else begin
				byte_in_row_q <= byte_in_row_q + BYTE_IDX_W'(1);
				ink_sum_q     <= ink_new;
			end
		end
	end

	// Row register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move && row_end;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && row_end) begin
			ink_s2  <= ink_new;
			gap_s2  <= gap_s1;
			wend_s2 <= wend_s1;
			row_s2  <= row_number_q;
		end
	end

	// Stage 2: landing candidate and best pick
	logic [ROW_INDEX_BITS-1:0]      image_row;
	logic [ROW_INDEX_BITS-1:0]      pad_ext;
	logic [ROW_INDEX_BITS-1:0]      land;
	logic [DIST_W-1:0]              land_w;
	logic [DIST_W-1:0]              target_w;
	logic [DIST_W-1:0]              land_dist;
	logic                           take;
	logic                           best_valid_next;
	logic [bgs_pkg::LANDING_W-1:0]  best_land_next;
	logic [bgs_pkg::LANDING_W-1:0]  best_dist_next;
	logic [bgs_pkg::MIN_RUN_W-1:0]  run_next;

	always_comb begin
		image_row = ROW_INDEX_BITS'(first_row_q) + row_s2;
		pad_ext   = ROW_INDEX_BITS'(gutter_pad_q);
		land      = (image_row >= pad_ext) ? image_row - pad_ext : '0;
		land_w    = DIST_W'(land);
		target_w  = DIST_W'(target_row_q);
		land_dist = (land_w > target_w) ? land_w - target_w : target_w - land_w;
		// earlier candidate keeps a tie
		take = !gap_s2 && (run_q >= min_gutter_q)
			&& (land_dist <= DIST_W'(tolerance_q))
			&& (!best_valid_q || land_dist < DIST_W'(best_dist_q));
		best_valid_next = best_valid_q || take;
		best_land_next  = take ? bgs_pkg::LANDING_W'(land) : best_land_q;
		best_dist_next  = take ? bgs_pkg::LANDING_W'(land_dist) : best_dist_q;
		// saturating gap run
		if (gap_s2) begin
			run_next = (run_q == '1) ? run_q : run_q + bgs_pkg::MIN_RUN_W'(1);
		end else begin
			run_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= '0;
			best_land_q  <= '0;
			best_dist_q  <= '0;
			best_valid_q <= 1'b0;
		end else if (s2_move) begin
			if (wend_s2) begin
				run_q        <= '0;
				best_land_q  <= '0;
				best_dist_q  <= '0;
				best_valid_q <= 1'b0;
			end else begin
				run_q        <= run_next;
				best_land_q  <= best_land_next;
				best_dist_q  <= best_dist_next;
				best_valid_q <= best_valid_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_ok) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_ink_q   <= bgs_pkg::INK_OUT_W'(ink_s2);
			out_gap_q   <= gap_s2;
			out_done_q  <= wend_s2;
			out_land_q  <= wend_s2
				? (best_valid_next ? best_land_next : target_row_q) : '0;
			out_found_q <= wend_s2 && best_valid_next;
		end
	end

	assign rows.valid         = out_valid_q;
	assign rows.row_ink       = out_ink_q;
	assign rows.row_is_gap    = out_gap_q;
	assign rows.window_done   = out_done_q;
	assign rows.landing_row   = out_land_q;
	assign rows.landing_found = out_found_q;

	// Checks
	a_landing_only_at_close: assert property (@(posedge clk) disable iff (!arst_n)
		rows.valid && !rows.window_done |-> rows.landing_row == '0 && !rows.landing_found)
		else $error("landing shown on a row that does not close the window");

	a_fallback_is_target: assert property (@(posedge clk) disable iff (!arst_n)
		rows.valid && rows.window_done && !rows.landing_found
		|-> rows.landing_row == target_row_q)
		else $error("window closed without a landing but result is not the target");

	a_row_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && row_end && wend_s1
		|=> row_number_q == '0 && byte_in_row_q == '0 && ink_sum_q == '0)
		else $error("row counters not cleared after window close");

	a_pick_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s2_move && wend_s2 |=> !best_valid_q && run_q == '0)
		else $error("landing pick not cleared after window close");

endmodule

`default_nettype wire

// File: test/tb.sv
// Gutter snap testbench: directed and random pixel windows checked against a row predictor.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_ROW_PIXELS = 4096;
	localparam int RESET_CYCLES   = 10;
	// pipeline is three registers deep; the settle wait adds margin on top
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int IDLE_SOME      = 48;
	localparam int IDLE_BOTH      = 17;

	typedef struct packed {
		logic [bgs_pkg::PIXEL_W-1:0] pixel_byte;
		logic                        window_end;
	} pix_req_t;

	typedef struct packed {
		logic [bgs_pkg::INK_OUT_W-1:0] row_ink;
		logic                          row_is_gap;
		logic                          window_done;
		logic [bgs_pkg::LANDING_W-1:0] landing_row;
		logic                          landing_found;
	} row_rep_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [bgs_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bgs_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	bgs_pix_if pix_ch ();
	bgs_row_if row_ch ();

	bitmap_gutter_snap_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixels    (pix_ch),
		.rows      (row_ch)
	);

	// Pending pixel requests and the row reports they should produce
	pix_req_t bytes_pending [$];
	row_rep_t rows_expected [$];
	int       mismatches = 0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_go        = 1'b0;
	bit hold_rows;

	// Register shadow
	logic [bgs_pkg::ROW_WIDTH_W-1:0] cfg_width;
	logic [bgs_pkg::PERCENT_W-1:0]   cfg_pct;
	logic [bgs_pkg::FLOOR_W-1:0]     cfg_floor;
	logic [bgs_pkg::ROWNUM_W-1:0]    cfg_target;
	logic [bgs_pkg::ROWNUM_W-1:0]    cfg_tol;
	logic [bgs_pkg::ROWNUM_W-1:0]    cfg_first;
	logic [bgs_pkg::MIN_RUN_W-1:0]   cfg_min_run;
	logic [bgs_pkg::PAD_W-1:0]       cfg_pad;

	// Window tracking state of the predictor
	int                            byte_pos;
	int                            ink_acc;
	logic [bgs_pkg::ROWNUM_W-1:0]  row_idx;
	logic [bgs_pkg::ROWNUM_W-1:0]  gap_run;
	logic [bgs_pkg::LANDING_W-1:0] best_row;
	logic [bgs_pkg::ROWNUM_W-1:0]  best_dist;
	bit                            best_ok;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_window();
		byte_pos  = 0;
		ink_acc   = 0;
		row_idx   = '0;
		gap_run   = '0;
		best_row  = '0;
		best_dist = '0;
		best_ok   = 1'b0;
	endfunction

	// Width after the clamp to the largest supported row
	function automatic int eff_width();
		return (cfg_width > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(cfg_width);
	endfunction

	function automatic int row_bytes();
		int w;
		w = eff_width();
		return (w == 0) ? 1 : (w + 7) / 8;
	endfunction

	// Advance the window by one pixel byte; returns 1 when a row report comes out
	function automatic bit snap_predict(input pix_req_t req, output row_rep_t rep);
		int                           w, budget, land, land_dist;
		logic [bgs_pkg::PIXEL_W-1:0]  px;
		logic [bgs_pkg::ROWNUM_W-1:0] img_row;
		bit                           last, gap;
		w    = eff_width();
		last = (byte_pos + 1 >= row_bytes());
		px   = req.pixel_byte;
		rep  = '0;
		// zero width carries no ink; a partial last byte keeps only its leading pixels
		if (w == 0)
			px = '0;
		else if (last && (w % 8) != 0)
			px &= 8'hFF << (8 - w % 8);
		ink_acc += $countones(px);
		if (!last && !req.window_end) begin
			byte_pos++;
			return 1'b0;
		end

		budget = w * int'(cfg_pct) / 100;
		if (budget < int'(cfg_floor))
			budget = int'(cfg_floor);
		gap = (w == 0) || (ink_acc <= budget);

		// gap run bookkeeping and landing pick on the first inked row after a gutter
		if (gap) begin
			if (gap_run != 16'hFFFF)
				gap_run++;
		end else begin
			if (gap_run >= cfg_min_run) begin
				img_row = cfg_first + row_idx;
				land = (img_row >= cfg_pad) ? int'(img_row) - int'(cfg_pad) : 0;
				land_dist = (land > int'(cfg_target)) ? land - int'(cfg_target)
					: int'(cfg_target) - land;
				if (land_dist <= int'(cfg_tol)
					&& (!best_ok || land_dist < int'(best_dist))) begin
					best_ok   = 1'b1;
					best_dist = land_dist[bgs_pkg::ROWNUM_W-1:0];
					best_row  = land[bgs_pkg::LANDING_W-1:0];
				end
			end
			gap_run = '0;
		end

		rep.row_ink     = ink_acc[bgs_pkg::INK_OUT_W-1:0];
		rep.row_is_gap  = gap;
		rep.window_done = req.window_end;
		if (req.window_end) begin
			rep.landing_row   = best_ok ? best_row : cfg_target;
			rep.landing_found = best_ok;
			clear_window();
		end else begin
			byte_pos = 0;
			ink_acc  = 0;
			row_idx++;
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Pixel request driver: holds an offered request until taken, idles at random
	always @(posedge clk) begin : pix_driver
		row_rep_t rep;
		bit       took;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else begin
			took = pix_ch.valid && pix_ch.ready;
			if (took) begin
				if (snap_predict(bytes_pending[0], rep))
					rows_expected.push_back(rep);
				void'(bytes_pending.pop_front());
			end
			if (!pix_ch.valid || took) begin
				if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pix_ch.valid      <= 1'b1;
					pix_ch.pixel_byte <= bytes_pending[0].pixel_byte;
					pix_ch.window_end <= bytes_pending[0].window_end;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Row report monitor: compares against the oldest expected report
	always @(posedge clk) begin : row_monitor
		row_rep_t want;
		if (!arst_n) begin
			row_ch.ready <= 1'b0;
		end else begin
			if (row_ch.valid && row_ch.ready) begin
				if (rows_expected.size() == 0) begin
					$error("row report with none expected: row_ink %0d window_done %0b",
						row_ch.row_ink, row_ch.window_done);
					mismatches++;
				end else begin
					want = rows_expected.pop_front();
					check_field("row_ink", want.row_ink, row_ch.row_ink);
					check_field("row_is_gap", want.row_is_gap, row_ch.row_is_gap);
					check_field("window_done", want.window_done, row_ch.window_done);
					check_field("landing_row", want.landing_row, row_ch.landing_row);
					check_field("landing_found", want.landing_found, row_ch.landing_found);
				end
			end
			row_ch.ready <= !hold_rows && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off so the block fills and stalls its input
	initial begin : rx_hold
		hold_rows = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_rows <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rows <= 1'b0;
	end

	task automatic set_reg(input bgs_pkg::cfg_reg_t idx,
		input logic [bgs_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			bgs_pkg::REG_ROW_WIDTH:       cfg_width   = val[bgs_pkg::ROW_WIDTH_W-1:0];
			bgs_pkg::REG_GAP_INK_PERCENT: cfg_pct     = val[bgs_pkg::PERCENT_W-1:0];
			bgs_pkg::REG_GAP_INK_FLOOR:   cfg_floor   = val[bgs_pkg::FLOOR_W-1:0];
			bgs_pkg::REG_TARGET_ROW:      cfg_target  = val;
			bgs_pkg::REG_TOLERANCE:       cfg_tol     = val;
			bgs_pkg::REG_FIRST_ROW:       cfg_first   = val;
			bgs_pkg::REG_MIN_GUTTER_ROWS: cfg_min_run = val[bgs_pkg::MIN_RUN_W-1:0];
			bgs_pkg::REG_GUTTER_PAD:      cfg_pad     = val[bgs_pkg::PAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait for every report, then let the pipeline empty of rowless requests
	task automatic wait_idle();
		while (bytes_pending.size() != 0 || rows_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct <= 0;         recv_stall_pct <= 0;         end
			1: begin send_idle_pct <= IDLE_SOME; recv_stall_pct <= 0;         end
			2: begin send_idle_pct <= 0;         recv_stall_pct <= IDLE_SOME; end
			default: begin send_idle_pct <= IDLE_BOTH; recv_stall_pct <= IDLE_BOTH; end
		endcase
	endtask

	function automatic void queue_byte(input logic [bgs_pkg::PIXEL_W-1:0] px, input bit wend);
		bytes_pending.push_back('{px, wend});
	endfunction

	// One row: gap rows are mostly blank, inked rows dense; a stray window end is noise
	function automatic int queue_row(input int nbytes, input bit inked, input bit closes);
		int                          k, cut, r;
		logic [bgs_pkg::PIXEL_W-1:0] px;
		bit                          wend;
		cut = nbytes - 1;
		if (closes && $urandom_range(99) < 15)
			cut = $urandom_range(0, nbytes - 1);
		for (k = 0; k <= cut; k++) begin
			r = $urandom_range(99);
			if (r < 4)
				px = 8'($urandom);
			else if (inked)
				px = (r < 45) ? 8'hFF : 8'($urandom);
			else
				px = (r < 80) ? 8'h00 : 8'h01 << $urandom_range(0, 7);
			wend = (closes && k == cut) || ($urandom_range(199) == 0);
			queue_byte(px, wend);
			if (wend)
				return k + 1;
		end
		return cut + 1;
	endfunction

	// A window of gap runs each followed by an inked row; the closing row may be blank
	function automatic int queue_window(input int nrows);
		int done, g, k, n, lim, nbytes;
		done   = 0;
		n      = 0;
		nbytes = row_bytes();
		lim    = (cfg_min_run > 8) ? 8 : int'(cfg_min_run);
		while (done < nrows) begin
			g = $urandom_range(0, lim + 2);
			for (k = 0; k < g && done < nrows - 1; k++) begin
				n += queue_row(nbytes, 1'b0, 1'b0);
				done++;
			end
			if (done == nrows - 1)
				n += queue_row(nbytes, $urandom_range(0, 1), 1'b1);
			else
				n += queue_row(nbytes, 1'b1, 1'b0);
			done++;
		end
		return n;
	endfunction

	function automatic void fill_windows(input int nitems);
		int queued, rows_max;
		queued   = 0;
		rows_max = 60 / row_bytes();
		if (rows_max < 1)
			rows_max = 1;
		if (rows_max > 24)
			rows_max = 24;
		while (queued < nitems)
			queued += queue_window($urandom_range(1, rows_max));
	endfunction

	task automatic pick_config();
		int                           r;
		logic [bgs_pkg::ROWNUM_W-1:0] first;
		r = $urandom_range(99);
		if (r < 6)
			set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd0);
		else if (r < 50)
			set_reg(bgs_pkg::REG_ROW_WIDTH, 16'($urandom_range(1, 16)));
		else if (r < 85)
			set_reg(bgs_pkg::REG_ROW_WIDTH, 16'($urandom_range(17, 64)));
		else
			set_reg(bgs_pkg::REG_ROW_WIDTH, 16'($urandom_range(65, 200)));

		r = $urandom_range(99);
		if (r < 15)
			set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'd0);
		else if (r < 25)
			set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'($urandom_range(101, 127)));
		else if (r < 30)
			set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'd100);
		else
			set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'($urandom_range(0, 20)));

		r = $urandom_range(99);
		if (r < 30)
			set_reg(bgs_pkg::REG_GAP_INK_FLOOR, 16'd0);
		else if (r < 90)
			set_reg(bgs_pkg::REG_GAP_INK_FLOOR, 16'($urandom_range(0, 12)));
		else
			set_reg(bgs_pkg::REG_GAP_INK_FLOOR, 16'($urandom_range(13, 8191)));

		// first row near zero, near the wrap point, or anywhere
		r = $urandom_range(99);
		if (r < 60)
			first = 16'($urandom_range(0, 200));
		else if (r < 80)
			first = 16'($urandom_range(65500, 65535));
		else
			first = 16'($urandom);
		set_reg(bgs_pkg::REG_FIRST_ROW, first);

		if ($urandom_range(99) < 80)
			set_reg(bgs_pkg::REG_TARGET_ROW, first + 16'($urandom_range(0, 60)));
		else
			set_reg(bgs_pkg::REG_TARGET_ROW, 16'($urandom));

		r = $urandom_range(99);
		if (r < 20)
			set_reg(bgs_pkg::REG_TOLERANCE, 16'd0);
		else if (r < 80)
			set_reg(bgs_pkg::REG_TOLERANCE, 16'($urandom_range(0, 30)));
		else if (r < 90)
			set_reg(bgs_pkg::REG_TOLERANCE, 16'hFFFF);
		else
			set_reg(bgs_pkg::REG_TOLERANCE, 16'($urandom));

		r = $urandom_range(99);
		if (r < 10)
			set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'd0);
		else if (r < 80)
			set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'($urandom_range(1, 4)));
		else if (r < 95)
			set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'($urandom_range(5, 10)));
		else
			set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'($urandom_range(11, 255)));

		if ($urandom_range(99) < 70)
			set_reg(bgs_pkg::REG_GUTTER_PAD, 16'($urandom_range(0, 6)));
		else
			set_reg(bgs_pkg::REG_GUTTER_PAD, 16'($urandom_range(0, 255)));
		close_writes();
	endtask

	initial begin : stimulus
		int p, k;
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		pix_ch.valid      = 1'b0;
		pix_ch.pixel_byte = '0;
		pix_ch.window_end = 1'b0;
		row_ch.ready      = 1'b0;
		cfg_width         = 13'd480;
		cfg_pct           = 7'd2;
		cfg_floor         = 13'd2;
		cfg_target        = '0;
		cfg_tol           = '0;
		cfg_first         = '0;
		cfg_min_run       = 8'd4;
		cfg_pad           = 8'd4;
		clear_window();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// One-byte rows: gutters of two, candidates at distance 3, 0 and a losing 3
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd8);
		set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'd0);
		set_reg(bgs_pkg::REG_GAP_INK_FLOOR, 16'd0);
		set_reg(bgs_pkg::REG_TARGET_ROW, 16'd14);
		set_reg(bgs_pkg::REG_TOLERANCE, 16'd3);
		set_reg(bgs_pkg::REG_FIRST_ROW, 16'd10);
		set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'd2);
		set_reg(bgs_pkg::REG_GUTTER_PAD, 16'd1);
		close_writes();
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		// Partial last byte is masked; an early window end is not
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd12);
		close_writes();
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hAA, 1'b1);
		wait_idle();

		// Zero width: every byte is a blank gap row
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd0);
		close_writes();
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h81, 1'b1);
		wait_idle();

		// Zero minimum run, row numbers wrapping past the top
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd1);
		set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'd0);
		set_reg(bgs_pkg::REG_GUTTER_PAD, 16'd0);
		set_reg(bgs_pkg::REG_TARGET_ROW, 16'd5);
		set_reg(bgs_pkg::REG_TOLERANCE, 16'hFFFF);
		set_reg(bgs_pkg::REG_FIRST_ROW, 16'd65534);
		close_writes();
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b1);
		wait_idle();

		// Width shrunk while a row is part way through
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd40);
		close_writes();
		for (k = 0; k < 3; k++)
			queue_byte(8'hFF, 1'b0);
		wait_idle();
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd16);
		close_writes();
		queue_byte(8'h0F, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h00, 1'b1);
		wait_idle();

		// Random settings, cycling through the idling patterns
		for (p = 0; p < 8; p++) begin
			set_idling(p % 4);
			pick_config();
			fill_windows(20);
			wait_idle();
		end

		// Receiver holds off while the sender keeps offering one-byte rows
		set_idling(0);
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd8);
		close_writes();
		hold_go <= 1'b1;
		fill_windows(40);
		wait_idle();

		// Register extremes with the widest row ended early, then a full row past the clamp
		set_idling(3);
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd4096);
		set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'd127);
		set_reg(bgs_pkg::REG_GAP_INK_FLOOR, 16'd8191);
		set_reg(bgs_pkg::REG_TARGET_ROW, 16'hFFFF);
		set_reg(bgs_pkg::REG_TOLERANCE, 16'hFFFF);
		set_reg(bgs_pkg::REG_FIRST_ROW, 16'hFFFF);
		set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'd255);
		set_reg(bgs_pkg::REG_GUTTER_PAD, 16'd255);
		close_writes();
		for (k = 0; k < 3; k++)
			queue_byte(8'($urandom), 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd8191);
		set_reg(bgs_pkg::REG_GAP_INK_PERCENT, 16'd50);
		set_reg(bgs_pkg::REG_GAP_INK_FLOOR, 16'd0);
		set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'd0);
		set_reg(bgs_pkg::REG_GUTTER_PAD, 16'd0);
		close_writes();
		for (k = 0; k < 512; k++)
			queue_byte(8'hFF, 1'b0);
		queue_byte(8'h0F, 1'b1);
		wait_idle();

		// Narrow rows under the extreme run length and pad
		set_idling(2);
		set_reg(bgs_pkg::REG_ROW_WIDTH, 16'd1);
		set_reg(bgs_pkg::REG_MIN_GUTTER_ROWS, 16'd255);
		set_reg(bgs_pkg::REG_GUTTER_PAD, 16'd255);
		close_writes();
		fill_windows(30);
		wait_idle();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Run limit, well beyond the slowest legal run
	initial begin : run_limit
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
